/* hdl/sdsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_pkg
// Types and constants shared by the signed decimal string parser.
// ----------------------------------------------------------------------------
package sdsp_pkg;

    typedef struct packed {
        logic        seen_digit;
        logic        is_negative;
        logic [31:0] magnitude;
        logic        number_ended;
        logic        error_seen;
        logic        overflow_seen;
    } t_state;

    localparam t_state STATE_CLEAR = '0;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

endpackage : sdsp_pkg
`default_nettype wire

/* hdl/sdsp_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_step
// Parser state update for one character, and the result for a final one.
// ----------------------------------------------------------------------------
module sdsp_step (
    input  wire logic [7:0]          i_char_code,
    input  wire logic                i_is_last,
    input  wire sdsp_pkg::t_state    i_state,
    output sdsp_pkg::t_state         o_state,
    output logic signed [31:0]       o_value,
    output logic [1:0]               o_status
);
    import sdsp_pkg::*;

    logic        w_is_digit;
    logic        w_is_space;
    logic [3:0]  w_digit_off;
    logic [31:0] w_limit;
    logic [35:0] w_next_mag;
    t_state      w_upd;

    always_comb begin
        w_is_digit  = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
        w_is_space  = (i_char_code == CHAR_TAB) || (i_char_code == CHAR_LF) ||
                      (i_char_code == CHAR_FF) || (i_char_code == CHAR_CR) ||
                      (i_char_code == CHAR_SPACE);
        w_digit_off = i_char_code[3:0];
        w_limit     = i_state.is_negative ? NEG_LIMIT : POS_LIMIT;
        w_next_mag  = {1'b0, i_state.magnitude, 3'b000} +
                      {3'b000, i_state.magnitude, 1'b0} +
                      {32'd0, w_digit_off};

        w_upd = i_state;
        if (!i_state.number_ended && !i_state.error_seen) begin
            if (w_is_digit) begin
                w_upd.seen_digit = 1'b1;
                if (w_next_mag > {4'd0, w_limit}) begin
                    w_upd.magnitude     = w_limit;
                    w_upd.overflow_seen = 1'b1;
                end else begin
                    w_upd.magnitude = w_next_mag[31:0];
                end
            end else if (i_state.seen_digit) begin
                w_upd.number_ended = 1'b1;
            end else if (w_is_space) begin
                w_upd.number_ended = i_state.number_ended;
            end else if (i_char_code == CHAR_MINUS) begin
                w_upd.is_negative = 1'b1;
            end else begin
                w_upd.error_seen = 1'b1;
            end
        end

        o_value = '0;
        if (w_upd.error_seen) begin
            o_status = ST_INVALID;
        end else if (!w_upd.seen_digit) begin
            o_status = ST_NO_DIGITS;
        end else begin
            o_value  = w_upd.is_negative ? signed'(~w_upd.magnitude + 32'd1)
                                         : signed'(w_upd.magnitude);
            o_status = w_upd.overflow_seen ? ST_OVERFLOW : ST_OK;
        end

        o_state = i_is_last ? STATE_CLEAR : w_upd;
    end

endmodule : sdsp_step
`default_nettype wire

/* hdl/signed_decimal_string_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_string_parser
// Streaming atoi: one ASCII character per word, a signed 32-bit value and a
// status word on the final character of each string.
// ----------------------------------------------------------------------------
// Takes one character every clock cycle while o_in_stall is low, with no
// bubbles between strings. A character is registered, then the parse state
// (sign, 32-bit magnitude and flags) is updated from it by one
// multiply-by-ten-and-add with a saturation compare; that state register
// loop sets the rate of one word per cycle. The result for a string is
// registered in an output register and held there while the downstream
// side stalls; the input stalls only when a final character must wait for
// that register to empty.
// ----------------------------------------------------------------------------
module signed_decimal_string_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_char_code,
    input  wire logic               i_is_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_value,
    output logic [1:0]              o_status
);
    import sdsp_pkg::*;

    logic               r_in_valid;
    logic [7:0]         r_in_char;
    logic               r_in_last;
    t_state             r_state;
    logic               r_out_valid;
    logic signed [31:0] r_value;
    logic [1:0]         r_status;

    t_state             n_state;
    logic signed [31:0] n_value;
    logic [1:0]         n_status;
    logic               w_out_free;
    logic               w_advance;
    logic               w_accept;

    sdsp_step u_step (
        .i_char_code (r_in_char),
        .i_is_last   (r_in_last),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_value     (n_value),
        .o_status    (n_status)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && (!r_in_last || w_out_free);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_state <= n_state;
            end

            if (w_advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char <= i_char_code;
            r_in_last <= i_is_last;
        end
        if (w_advance && r_in_last) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

endmodule : signed_decimal_string_parser
`default_nettype wire

/* hdl/sdsp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsp_checker
// Port-level checks for the signed decimal string parser, bound to the top.
// ----------------------------------------------------------------------------
module sdsp_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_stall,
    input  wire logic               i_is_last,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [31:0] o_value,
    input  wire logic [1:0]         o_status
);
    import sdsp_pkg::*;

    logic w_last_accept;

    assign w_last_accept = i_in_valid && !o_in_stall && i_is_last;

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_value) && $stable(o_status))
        else $error("result word changed while stalled");

    // failed parse reports zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_INVALID || o_status == ST_NO_DIGITS)
            |-> o_value == 32'sd0)
        else $error("nonzero value on failed parse");

    // overflow reports a saturated value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OVERFLOW
            |-> (o_value == 32'sh7FFF_FFFF || o_value == 32'sh8000_0000))
        else $error("overflow value not saturated");

    // a fresh result follows an accepted final character
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(o_out_valid) && o_out_valid |-> $past(w_last_accept, 2))
        else $error("result word without a final character");

endmodule : sdsp_checker

bind signed_decimal_string_parser sdsp_checker u_sdsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_is_last   (i_is_last),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value     (o_value),
    .o_status    (o_status)
);
`default_nettype wire

/* bench/signed_decimal_string_parser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_string_parser_test
// Self-checking bench for the streaming signed decimal string parser.
// ----------------------------------------------------------------------------
// Strings are sent one character per word, with the final character flagged.
// A behavioral parser in the bench follows every accepted character and
// queues the value and status due at the end of each string. Every result
// word is checked against the oldest queued entry. The strings mix
// well-formed numbers (leading blanks and signs, values around the
// saturation limits, trailing junk) with random noise and strings that go
// bad before the first digit. Sender gaps and receiver stalls vary over the
// run.
// ----------------------------------------------------------------------------
module signed_decimal_string_parser_test;
    import sdsp_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_parsed;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [7:0]         char_code = 8'd0;
    logic               is_last = 1'b0;
    logic               out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [31:0] o_value;
    logic [1:0]         o_status;

    t_state     parse_st = STATE_CLEAR;
    t_parsed    pending_numbers[$];
    logic [7:0] line_buf[$];
    int         errors = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b0;
    t_rx_mode   rx_mode = RX_OPEN;
    logic [3:0] rx_phase = 4'd0;

    signed_decimal_string_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (char_code),
        .i_is_last   (is_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_value     (o_value),
        .o_status    (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 4'd1;
        case (rx_mode)
            RX_OPEN:    out_stall <= 1'b0;
            RX_RANDOM:  out_stall <= 1'($urandom_range(0, 1));
            RX_PATTERN: out_stall <= (rx_phase < 4'd11);
            default:    out_stall <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        t_parsed want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_numbers.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual value %0d status %0d",
                         $time, o_value, o_status);
            end else begin
                want = pending_numbers.pop_front();
                if (o_value !== want.value) begin
                    errors++;
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, want.value, o_value);
                end
                if (o_status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_status);
                end
            end
        end
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_TAB || c == CHAR_LF || c == CHAR_FF || c == CHAR_CR
            || c == CHAR_SPACE;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return CHAR_TAB;
            1:       return CHAR_LF;
            2:       return CHAR_FF;
            3:       return CHAR_CR;
            default: return CHAR_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 3))
            0:       return 8'(CHAR_ZERO + $urandom_range(0, 9));
            1:       return pick_blank();
            2:       return CHAR_MINUS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // bench-side parser, run on each accepted character
    task automatic parse_char(input logic [7:0] c, input logic last);
        logic [31:0] limit;
        logic [35:0] next_mag;
        t_parsed     res;
        if (!(parse_st.number_ended || parse_st.error_seen)) begin
            if (is_digit(c)) begin
                limit = parse_st.is_negative ? NEG_LIMIT : POS_LIMIT;
                next_mag = {4'd0, parse_st.magnitude} * 36'd10 + 36'(c - CHAR_ZERO);
                parse_st.seen_digit = 1'b1;
                if (next_mag > {4'd0, limit}) begin
                    parse_st.magnitude = limit;
                    parse_st.overflow_seen = 1'b1;
                end else begin
                    parse_st.magnitude = next_mag[31:0];
                end
            end else if (parse_st.seen_digit) begin
                parse_st.number_ended = 1'b1;
            end else if (c == CHAR_MINUS) begin
                parse_st.is_negative = 1'b1;
            end else if (!is_blank(c)) begin
                parse_st.error_seen = 1'b1;
            end
        end
        if (last) begin
            res.value = '0;
            if (parse_st.error_seen) begin
                res.status = ST_INVALID;
            end else if (!parse_st.seen_digit) begin
                res.status = ST_NO_DIGITS;
            end else begin
                res.value = parse_st.is_negative ? -parse_st.magnitude : parse_st.magnitude;
                res.status = parse_st.overflow_seen ? ST_OVERFLOW : ST_OK;
            end
            pending_numbers.push_back(res);
            parse_st = STATE_CLEAR;
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        if (gaps_on && burst_left == 0) begin
            repeat ($urandom_range(1, 5)) begin
                @(negedge i_clk);
                in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        char_code = c;
        is_last = last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        parse_char(c, last);
    endtask

    task automatic send_line();
        if ($urandom_range(0, 15) == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        end
        foreach (line_buf[i]) begin
            send_char(line_buf[i], i == line_buf.size() - 1);
        end
        line_buf.delete();
    endtask

    task automatic append_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endtask

    task automatic append_decimal(input longint unsigned v);
        logic [7:0] digits[$];
        do begin
            digits.push_front(8'(CHAR_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) begin
            line_buf.push_back(digits[i]);
        end
    endtask

    task automatic append_lead();
        repeat ($urandom_range(0, 3)) begin
            line_buf.push_back(($urandom_range(0, 3) == 0) ? CHAR_MINUS : pick_blank());
        end
    endtask

    task automatic test_directed();
        append_str("-0");
        send_line();
        line_buf = '{CHAR_TAB, CHAR_LF, CHAR_FF, CHAR_CR, CHAR_MINUS, CHAR_SPACE};
        send_line();
        append_str("+1");
        send_line();
        line_buf.push_back(8'h00);
        send_line();
        append_str("7");
        line_buf.push_back(8'hFF);
        send_line();
        append_str("-9999999999");
        send_line();
    endtask

    task automatic test_number_strings(input int count);
        repeat (count) begin
            append_lead();
            case ($urandom_range(0, 4))
                0: append_decimal($urandom_range(0, 999));
                1: append_decimal($urandom);
                2: append_decimal(64'd2147483638 + $urandom_range(0, 20));
                3: repeat ($urandom_range(11, 14)) begin
                    line_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                end
                default: begin
                    repeat ($urandom_range(1, 4)) line_buf.push_back(CHAR_ZERO);
                    append_decimal($urandom_range(0, 99));
                end
            endcase
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
            end
            send_line();
        end
    endtask

    task automatic test_noise_strings(input int count);
        repeat (count) begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(pick_char());
            send_line();
        end
    endtask

    task automatic test_broken_strings(input int count);
        logic [7:0] bad;
        repeat (count) begin
            append_lead();
            if ($urandom_range(0, 1) == 0) begin
                // only blanks and signs
                line_buf.push_back(($urandom_range(0, 1) == 0) ? CHAR_MINUS : pick_blank());
            end else begin
                do begin
                    bad = 8'($urandom_range(0, 255));
                end while (is_digit(bad) || is_blank(bad) || bad == CHAR_MINUS);
                line_buf.push_back(bad);
                append_decimal($urandom_range(0, 9999));
            end
            send_line();
        end
    endtask

    // sender holds off until every queued result is out
    task automatic test_drain_pause();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_numbers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
        test_number_strings(45);
        test_drain_pause();
        gaps_on = 1'b0;
        rx_mode = RX_OPEN;
        test_noise_strings(40);
        rx_mode = RX_PATTERN;
        test_broken_strings(30);
        gaps_on = 1'b1;
        test_number_strings(45);
        test_noise_strings(30);

        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_numbers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending_numbers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
